/* rtl/mvn_pkg.sv */
`default_nettype none
package mvn_pkg;

    localparam int VertexSlots = 1024;
    localparam int IdxBits     = $clog2(VertexSlots);
    localparam int CoordBits   = 16;
    localparam int FracBits    = 14;
    localparam int SumBits     = 32;
    localparam int CntBits     = 16;
    localparam int CrossBits   = 2 * (CoordBits + 1) + 1;
    localparam int MagBits     = 31;
    localparam int SqBits      = 64;
    localparam int RootBits    = 32;
    localparam int QuotBits    = MagBits + FracBits;
    localparam int AccBits     = 3 * SumBits + CntBits;

    typedef logic [1:0] op_t;
    localparam op_t OP_LOAD  = 2'd0;
    localparam op_t OP_TRI   = 2'd1;
    localparam op_t OP_READ  = 2'd2;
    localparam op_t OP_CLEAR = 2'd3;

    // Handshake between the sequencer and the normalizer
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } norm_ctl_t;

endpackage
`default_nettype wire

/* rtl/mesh_vertex_normal_engine.sv */
`default_nettype none
// Channel  Direction  Beat carries
// in       input      operation, vertex_index, vertex_x/y/z, corner_a/b/c
// out      output     out_index, normal_x/y/z, face_count, no_normal
//
// Load writes the vertex table. Triangle reads corners A, B, C, forms the cross product, runs
// the normalizer (shift, square, sum, 32-step root, three divisions) and read-modify-writes
// each corner's accumulator. Read fetches the sum, runs the normalizer and sends one beat.
// Clear sweeps all 1024 accumulator entries, one per cycle; reset runs the same sweep.
// in_stall is high while any item is in progress. A result waits in the output register
// while out_stall is high; a later read holds in its last cycle until that beat leaves.
module mesh_vertex_normal_engine
    import mvn_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  operation,
    input  wire logic [IdxBits-1:0]          vertex_index,
    input  wire logic signed [CoordBits-1:0] vertex_x,
    input  wire logic signed [CoordBits-1:0] vertex_y,
    input  wire logic signed [CoordBits-1:0] vertex_z,
    input  wire logic [IdxBits-1:0]          corner_a,
    input  wire logic [IdxBits-1:0]          corner_b,
    input  wire logic [IdxBits-1:0]          corner_c,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [IdxBits-1:0]               out_index,
    output logic signed [15:0]               normal_x,
    output logic signed [15:0]               normal_y,
    output logic signed [15:0]               normal_z,
    output logic [CntBits-1:0]               face_count,
    output logic                             no_normal
);

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_VRD    = 11'b00000000100,
        S_VWAIT  = 11'b00000001000,
        S_NORM   = 11'b00000010000,
        S_NWAIT  = 11'b00000100000,
        S_ARD    = 11'b00001000000,
        S_AWB    = 11'b00010000000,
        S_RRD    = 11'b00100000000,
        S_RWAIT  = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } st_t;

    st_t                      st_reg;
    logic [IdxBits-1:0]       clr_reg;
    logic [IdxBits-1:0]       cn_reg [3];
    logic [1:0]               k_reg;
    logic signed [CoordBits-1:0] va_reg [3];
    logic signed [CoordBits:0]   vb_reg [3];
    logic signed [CoordBits:0]   cr_reg [3];
    logic signed [CrossBits-1:0] nv_reg [3];

    logic [3*CoordBits-1:0]   vmem [VertexSlots];
    logic [3*CoordBits-1:0]   vrd_reg;
    logic [AccBits-1:0]       amem [VertexSlots];
    logic [AccBits-1:0]       ard_reg;

    logic                     ov_reg;
    logic [IdxBits-1:0]       oi_reg;
    logic signed [15:0]       ox_reg, oy_reg, oz_reg;
    logic [CntBits-1:0]       oc_reg;
    logic                     on_reg;
    logic                     is_read_reg;
    logic [IdxBits-1:0]       idx_reg;
    logic [CntBits-1:0]       cnt_reg;

    norm_ctl_t                nctl;
    logic                     nstart;
    logic signed [FracBits+1:0] ux, uy, uz;
    logic                     nzero;

    logic                     acc_we;
    logic [IdxBits-1:0]       acc_waddr;
    logic [AccBits-1:0]       acc_wdata;
    logic [IdxBits-1:0]       acc_raddr;
    logic [IdxBits-1:0]       v_raddr;
    logic                     accept;

    logic signed [SumBits-1:0] ns [3];
    logic [CntBits-1:0]        ncnt;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (st_reg != S_IDLE);

    // Saturating accumulate of the unit normal into one entry
    function automatic logic signed [SumBits-1:0] sat_add(
        input logic signed [SumBits-1:0]    a,
        input logic signed [FracBits+1:0]   b
    );
        logic signed [SumBits:0] t;
        t = SumBits'(0) + {a[SumBits-1], a} + (SumBits+1)'(b);
        if (t[SumBits] != t[SumBits-1])
            return t[SumBits] ? {1'b1, {(SumBits-1){1'b0}}} : {1'b0, {(SumBits-1){1'b1}}};
        return t[SumBits-1:0];
    endfunction

    always_comb
    begin
        ns[0] = sat_add(ard_reg[AccBits-1 -: SumBits], ux);
        ns[1] = sat_add(ard_reg[AccBits-1-SumBits -: SumBits], uy);
        ns[2] = sat_add(ard_reg[AccBits-1-2*SumBits -: SumBits], uz);
        ncnt  = (ard_reg[CntBits-1:0] == '1) ? ard_reg[CntBits-1:0]
                                             : ard_reg[CntBits-1:0] + 1'b1;
        acc_we    = (st_reg == S_CLEAR) || (st_reg == S_AWB);
        acc_waddr = (st_reg == S_CLEAR) ? clr_reg : cn_reg[k_reg];
        acc_wdata = (st_reg == S_CLEAR) ? '0 : {ns[0], ns[1], ns[2], ncnt};
        acc_raddr = (st_reg == S_RRD) ? idx_reg : cn_reg[k_reg];
        v_raddr   = cn_reg[k_reg];
        nstart    = (st_reg == S_NWAIT) && !nctl.busy;
    end

    // Vertex table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_LOAD)
            vmem[vertex_index] <= {vertex_x, vertex_y, vertex_z};
        vrd_reg <= vmem[v_raddr];
    end

    // Accumulator table
    always_ff @(posedge clk)
    begin
        if (acc_we)
            amem[acc_waddr] <= acc_wdata;
        ard_reg <= amem[acc_raddr];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_CLEAR;
            clr_reg <= '0;
            ov_reg  <= 1'b0;
            k_reg   <= '0;
        end
        else
        begin
            // drop the result beat once taken, unless a new one replaces it
            if (ov_reg && !out_stall && st_reg != S_OUT)
                ov_reg <= 1'b0;
            case (st_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IdxBits'(VertexSlots - 1))
                        st_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        k_reg     <= '0;
                        cn_reg[0] <= corner_a;
                        cn_reg[1] <= corner_b;
                        cn_reg[2] <= corner_c;
                        idx_reg   <= vertex_index;
                        case (operation)
                            OP_TRI:   st_reg <= S_VRD;
                            OP_READ:  st_reg <= S_RRD;
                            OP_CLEAR:
                            begin
                                clr_reg <= '0;
                                st_reg  <= S_CLEAR;
                            end
                            default:  st_reg <= S_IDLE;
                        endcase
                    end
                end
                // read corners A, B, C in turn
                S_VRD:
                begin
                    st_reg <= S_VWAIT;
                end
                S_VWAIT:
                begin
                    if (k_reg == 2'd0)
                    begin
                        va_reg[0] <= vrd_reg[3*CoordBits-1 -: CoordBits];
                        va_reg[1] <= vrd_reg[2*CoordBits-1 -: CoordBits];
                        va_reg[2] <= vrd_reg[CoordBits-1:0];
                    end
                    else
                    begin
                        // hold edge from A
                        if (k_reg == 2'd1)
                        begin
                            vb_reg[0] <= (CoordBits+1)'($signed(vrd_reg[3*CoordBits-1 -: CoordBits]))
                                         - (CoordBits+1)'(va_reg[0]);
                            vb_reg[1] <= (CoordBits+1)'($signed(vrd_reg[2*CoordBits-1 -: CoordBits]))
                                         - (CoordBits+1)'(va_reg[1]);
                            vb_reg[2] <= (CoordBits+1)'($signed(vrd_reg[CoordBits-1:0]))
                                         - (CoordBits+1)'(va_reg[2]);
                        end
                    end
                    if (k_reg == 2'd2)
                    begin
                        cr_reg[0] <= (CoordBits+1)'($signed(vrd_reg[3*CoordBits-1 -: CoordBits]))
                                     - (CoordBits+1)'(va_reg[0]);
                        cr_reg[1] <= (CoordBits+1)'($signed(vrd_reg[2*CoordBits-1 -: CoordBits]))
                                     - (CoordBits+1)'(va_reg[1]);
                        cr_reg[2] <= (CoordBits+1)'($signed(vrd_reg[CoordBits-1:0]))
                                     - (CoordBits+1)'(va_reg[2]);
                        k_reg  <= '0;
                        st_reg <= S_NORM;
                    end
                    else
                    begin
                        k_reg  <= k_reg + 2'd1;
                        st_reg <= S_VRD;
                    end
                end
                S_NORM:
                begin
                    st_reg <= S_NWAIT;
                end
                S_NWAIT:
                begin
                    if (nctl.done)
                    begin
                        k_reg  <= '0;
                        st_reg <= is_read_reg ? S_OUT : S_ARD;
                    end
                end
                // read-modify-write each corner's accumulator
                S_ARD:
                begin
                    st_reg <= S_AWB;
                end
                S_AWB:
                begin
                    if (k_reg == 2'd2)
                    begin
                        st_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg  <= k_reg + 2'd1;
                        st_reg <= S_ARD;
                    end
                end
                S_RRD:
                begin
                    st_reg <= S_RWAIT;
                end
                S_RWAIT:
                begin
                    cnt_reg <= ard_reg[CntBits-1:0];
                    st_reg  <= S_NORM;
                end
                // hold until the output register is free or being taken
                S_OUT:
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        oi_reg <= idx_reg;
                        oc_reg <= cnt_reg;
                        ox_reg <= 16'(ux);
                        oy_reg <= 16'(uy);
                        oz_reg <= 16'(uz);
                        on_reg <= nzero;
                        ov_reg <= 1'b1;
                        st_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Hold the vector fed to the normalizer: cross product or read sum
    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && accept)
            is_read_reg <= (operation == OP_READ);
        if (st_reg == S_RWAIT)
        begin
            nv_reg[0] <= CrossBits'($signed(ard_reg[AccBits-1 -: SumBits]));
            nv_reg[1] <= CrossBits'($signed(ard_reg[AccBits-1-SumBits -: SumBits]));
            nv_reg[2] <= CrossBits'($signed(ard_reg[AccBits-1-2*SumBits -: SumBits]));
        end
        else if (st_reg == S_NORM && !is_read_reg)
        begin
            // e1 = vb_reg, e2 = cr_reg (held as C - A)
            nv_reg[0] <= CrossBits'(vb_reg[1] * cr_reg[2]) - CrossBits'(vb_reg[2] * cr_reg[1]);
            nv_reg[1] <= CrossBits'(vb_reg[2] * cr_reg[0]) - CrossBits'(vb_reg[0] * cr_reg[2]);
            nv_reg[2] <= CrossBits'(vb_reg[0] * cr_reg[1]) - CrossBits'(vb_reg[1] * cr_reg[0]);
        end
    end

    mvn_normalize u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (nstart),
        .vec_x    (nv_reg[0]),
        .vec_y    (nv_reg[1]),
        .vec_z    (nv_reg[2]),
        .ctl      (nctl),
        .unit_x   (ux),
        .unit_y   (uy),
        .unit_z   (uz),
        .zero_len (nzero)
    );

    assign out_valid  = ov_reg;
    assign out_index  = oi_reg;
    assign normal_x   = ox_reg;
    assign normal_y   = oy_reg;
    assign normal_z   = oz_reg;
    assign face_count = oc_reg;
    assign no_normal  = on_reg;

endmodule
`default_nettype wire

/* rtl/mvn_normalize.sv */
`default_nettype none
// Normalize a signed vector to Q1.FracBits: magnitude shift, bit-pair
// square root, then three restoring divisions, one bit per cycle.
module mvn_normalize
    import mvn_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic signed [CrossBits-1:0]  vec_x,
    input  wire logic signed [CrossBits-1:0]  vec_y,
    input  wire logic signed [CrossBits-1:0]  vec_z,
    output norm_ctl_t                         ctl,
    output logic signed [FracBits+1:0]        unit_x,
    output logic signed [FracBits+1:0]        unit_y,
    output logic signed [FracBits+1:0]        unit_z,
    output logic                              zero_len
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SHIFT = 7'b0000010,
        S_SQ    = 7'b0000100,
        S_SUM   = 7'b0001000,
        S_ROOT  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } nst_t;

    nst_t                   st_reg;
    logic [CrossBits-1:0]   mag_reg [3];
    logic [2:0]             neg_reg;
    logic [1:0]             comp_reg;
    logic [SqBits-1:0]      sq_reg [3];
    logic [SqBits-1:0]      rem_reg;
    logic [SqBits-1:0]      root_reg;
    logic [5:0]             step_reg;
    logic [QuotBits-1:0]    num_reg;
    logic [RootBits:0]      part_reg;
    logic [QuotBits-1:0]    quo_reg;
    logic [FracBits:0]      res_reg [3];
    logic                   zero_reg;

    logic [CrossBits-1:0]   abs_x, abs_y, abs_z, top;
    logic [SqBits-1:0]      trial;
    logic [SqBits-1:0]      bit_val;
    logic [RootBits:0]      part_sh;

    assign abs_x = vec_x[CrossBits-1] ? CrossBits'(-vec_x) : CrossBits'(vec_x);
    assign abs_y = vec_y[CrossBits-1] ? CrossBits'(-vec_y) : CrossBits'(vec_y);
    assign abs_z = vec_z[CrossBits-1] ? CrossBits'(-vec_z) : CrossBits'(vec_z);

    always_comb
    begin
        top = mag_reg[0] | mag_reg[1] | mag_reg[2];
        // root iteration: bit = 4^step
        bit_val = SqBits'(1) << {step_reg[4:0], 1'b0};
        trial   = root_reg + bit_val;
        part_sh = {part_reg[RootBits-1:0], num_reg[QuotBits-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mag_reg[0] <= abs_x;
                        mag_reg[1] <= abs_y;
                        mag_reg[2] <= abs_z;
                        neg_reg    <= {vec_z[CrossBits-1], vec_y[CrossBits-1],
                                       vec_x[CrossBits-1]};
                        st_reg     <= S_SHIFT;
                    end
                end
                // shift right until every magnitude fits in 31 bits
                S_SHIFT:
                begin
                    if (top[CrossBits-1:MagBits] != '0)
                    begin
                        mag_reg[0] <= mag_reg[0] >> 1;
                        mag_reg[1] <= mag_reg[1] >> 1;
                        mag_reg[2] <= mag_reg[2] >> 1;
                    end
                    else
                    begin
                        zero_reg <= (top == '0);
                        st_reg   <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    sq_reg[0] <= SqBits'(mag_reg[0][MagBits-1:0])
                                 * SqBits'(mag_reg[0][MagBits-1:0]);
                    sq_reg[1] <= SqBits'(mag_reg[1][MagBits-1:0])
                                 * SqBits'(mag_reg[1][MagBits-1:0]);
                    sq_reg[2] <= SqBits'(mag_reg[2][MagBits-1:0])
                                 * SqBits'(mag_reg[2][MagBits-1:0]);
                    st_reg    <= S_SUM;
                end
                S_SUM:
                begin
                    rem_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
                    root_reg <= '0;
                    step_reg <= 6'd31;
                    st_reg   <= zero_reg ? S_DONE : S_ROOT;
                    if (zero_reg)
                    begin
                        res_reg[0] <= '0;
                        res_reg[1] <= '0;
                        res_reg[2] <= '0;
                    end
                end
                // one result bit per cycle
                S_ROOT:
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg  <= rem_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_val;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    if (step_reg == 6'd0)
                    begin
                        comp_reg <= 2'd0;
                        step_reg <= 6'(QuotBits);
                        num_reg  <= {mag_reg[0][MagBits-1:0], FracBits'(0)};
                        part_reg <= '0;
                        st_reg   <= S_DIV;
                    end
                    else
                    begin
                        step_reg <= step_reg - 6'd1;
                    end
                end
                // restoring division, one quotient bit per cycle
                S_DIV:
                begin
                    if (step_reg != 6'd0)
                    begin
                        if (part_sh >= {1'b0, root_reg[RootBits-1:0]})
                        begin
                            part_reg <= part_sh - {1'b0, root_reg[RootBits-1:0]};
                            quo_reg  <= {quo_reg[QuotBits-2:0], 1'b1};
                        end
                        else
                        begin
                            part_reg <= part_sh;
                            quo_reg  <= {quo_reg[QuotBits-2:0], 1'b0};
                        end
                        num_reg  <= num_reg << 1;
                        step_reg <= step_reg - 6'd1;
                    end
                    else
                    begin
                        res_reg[comp_reg] <= quo_reg[FracBits:0];
                        part_reg <= '0;
                        step_reg <= 6'(QuotBits);
                        if (comp_reg == 2'd2)
                        begin
                            st_reg <= S_DONE;
                        end
                        else
                        begin
                            comp_reg <= comp_reg + 2'd1;
                            num_reg  <= {mag_reg[comp_reg + 2'd1][MagBits-1:0],
                                         FracBits'(0)};
                        end
                    end
                end
                S_DONE:
                begin
                    st_reg <= S_IDLE;
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign ctl      = {start, (st_reg != S_IDLE), (st_reg == S_DONE)};
    assign zero_len = zero_reg;
    assign unit_x = neg_reg[0] ? -$signed({1'b0, res_reg[0]}) : $signed({1'b0, res_reg[0]});
    assign unit_y = neg_reg[1] ? -$signed({1'b0, res_reg[1]}) : $signed({1'b0, res_reg[1]});
    assign unit_z = neg_reg[2] ? -$signed({1'b0, res_reg[2]}) : $signed({1'b0, res_reg[2]});

endmodule
`default_nettype wire

/* tb/sv/mesh_vertex_normal_engine_tb.sv */
`default_nettype none
module mesh_vertex_normal_engine_tb;
    import mvn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CycleLimit = 2000000;
    localparam int     DrainCycles = 1200;
    localparam int     HoldCycles = 600;

    typedef struct {
        logic [IdxBits-1:0] idx;
        logic [15:0]        nx;
        logic [15:0]        ny;
        logic [15:0]        nz;
        logic [CntBits-1:0] cnt;
        logic               none;
    } normal_beat_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [1:0]                  operation;
    logic [IdxBits-1:0]          vertex_index;
    logic signed [CoordBits-1:0] vertex_x;
    logic signed [CoordBits-1:0] vertex_y;
    logic signed [CoordBits-1:0] vertex_z;
    logic [IdxBits-1:0]          corner_a;
    logic [IdxBits-1:0]          corner_b;
    logic [IdxBits-1:0]          corner_c;
    logic                        out_valid;
    logic                        out_stall;
    logic [IdxBits-1:0]          out_index;
    logic signed [15:0]          normal_x;
    logic signed [15:0]          normal_y;
    logic signed [15:0]          normal_z;
    logic [CntBits-1:0]          face_count;
    logic                        no_normal;

    mesh_vertex_normal_engine u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .vertex_index(vertex_index),
        .vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
        .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_index(out_index), .normal_x(normal_x), .normal_y(normal_y),
        .normal_z(normal_z), .face_count(face_count), .no_normal(no_normal)
    );

    // Shadow of the block's tables
    longint       vert_pos [VertexSlots][3];
    bit           vert_loaded [VertexSlots];
    int           loaded_list [$];
    longint       acc_sum [VertexSlots][3];
    int           touch_cnt [VertexSlots];
    normal_beat_t normal_q [$];

    int     errors;
    int     beats_sent;
    int     reads_checked;
    int     tris_sent;
    longint cycle_cnt;
    bit     calm;
    bit     hold_go;
    bit     hold_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned root_of(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale a vector to Q1.14 unit length, truncating toward zero
    function automatic bit unit_of(input longint cx, input longint cy, input longint cz,
                                   output longint nx, output longint ny, output longint nz);
        longint          cv [3];
        longint          nv [3];
        longint unsigned mag [3];
        longint unsigned top;
        longint unsigned s;
        longint unsigned r;
        longint unsigned q;
        int              k;
        cv[0] = cx; cv[1] = cy; cv[2] = cz;
        top = 0;
        s = 0;
        k = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (cv[i] < 0) ? -cv[i] : cv[i];
            if (mag[i] > top)
                top = mag[i];
            nv[i] = 0;
        end
        nx = 0; ny = 0; nz = 0;
        if (top == 0)
            return 1'b1;
        while ((top >> k) >= 64'h8000_0000)
            k++;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = mag[i] >> k;
            s = s + mag[i] * mag[i];
        end
        r = root_of(s);
        for (int i = 0; i < 3; i++)
        begin
            q = (mag[i] << FracBits) / r;
            nv[i] = (cv[i] < 0) ? -longint'(q) : longint'(q);
        end
        nx = nv[0]; ny = nv[1]; nz = nv[2];
        return 1'b0;
    endfunction

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Update the shadow tables for one accepted beat
    task automatic predict_beat(input op_t op, input int idx,
                                input logic signed [15:0] x, input logic signed [15:0] y,
                                input logic signed [15:0] z,
                                input int ca, input int cb, input int cc);
        longint       e1 [3];
        longint       e2 [3];
        longint       nx, ny, nz, cx, cy, cz;
        int           corners [3];
        normal_beat_t beat;
        bit           none;
        corners[0] = ca; corners[1] = cb; corners[2] = cc;
        case (op)
            OP_LOAD:
            begin
                vert_pos[idx][0] = x;
                vert_pos[idx][1] = y;
                vert_pos[idx][2] = z;
                if (!vert_loaded[idx])
                    loaded_list.push_back(idx);
                vert_loaded[idx] = 1'b1;
            end
            OP_TRI:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1[i] = vert_pos[cb][i] - vert_pos[ca][i];
                    e2[i] = vert_pos[cc][i] - vert_pos[ca][i];
                end
                cx = e1[1] * e2[2] - e1[2] * e2[1];
                cy = e1[2] * e2[0] - e1[0] * e2[2];
                cz = e1[0] * e2[1] - e1[1] * e2[0];
                none = unit_of(cx, cy, cz, nx, ny, nz);
                for (int i = 0; i < 3; i++)
                begin
                    acc_sum[corners[i]][0] = sat32(acc_sum[corners[i]][0] + nx);
                    acc_sum[corners[i]][1] = sat32(acc_sum[corners[i]][1] + ny);
                    acc_sum[corners[i]][2] = sat32(acc_sum[corners[i]][2] + nz);
                    if (touch_cnt[corners[i]] != 65535)
                        touch_cnt[corners[i]]++;
                end
                tris_sent++;
            end
            OP_READ:
            begin
                none = unit_of(acc_sum[idx][0], acc_sum[idx][1], acc_sum[idx][2],
                               nx, ny, nz);
                beat.idx  = IdxBits'(idx);
                beat.nx   = nx[15:0];
                beat.ny   = ny[15:0];
                beat.nz   = nz[15:0];
                beat.cnt  = CntBits'(touch_cnt[idx]);
                beat.none = none;
                normal_q.push_back(beat);
            end
            default:
            begin
                for (int i = 0; i < VertexSlots; i++)
                begin
                    acc_sum[i][0] = 0;
                    acc_sum[i][1] = 0;
                    acc_sum[i][2] = 0;
                    touch_cnt[i] = 0;
                end
            end
        endcase
    endtask

    // Offer one beat, hold it until accepted, then predict
    task automatic send_beat(input op_t op, input int idx,
                             input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z,
                             input int ca, input int cb, input int cc);
        int gap;
        if (!calm && $urandom_range(99) < 18)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        vertex_index <= IdxBits'(idx);
        vertex_x     <= x;
        vertex_y     <= y;
        vertex_z     <= z;
        corner_a     <= IdxBits'(ca);
        corner_b     <= IdxBits'(cb);
        corner_c     <= IdxBits'(cc);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_beat(op, idx, x, y, z, ca, cb, cc);
        beats_sent++;
    endtask

    task automatic send_load(input int idx, input int x, input int y, input int z);
        send_beat(OP_LOAD, idx, 16'(x), 16'(y), 16'(z), $urandom_range(1023),
                  $urandom_range(1023), $urandom_range(1023));
    endtask

    task automatic send_tri(input int ca, input int cb, input int cc);
        send_beat(OP_TRI, $urandom_range(1023), 16'($urandom), 16'($urandom),
                  16'($urandom), ca, cb, cc);
    endtask

    task automatic send_read(input int idx);
        send_beat(OP_READ, idx, 16'($urandom), 16'($urandom), 16'($urandom),
                  $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
    endtask

    task automatic send_clear();
        send_beat(OP_CLEAR, $urandom_range(1023), 16'($urandom), 16'($urandom),
                  16'($urandom), $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(1023));
    endtask

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    // Extremes, degenerate and cancelling faces, repeated corners, clear
    task automatic test_directed();
        send_load(0, -32768, -32768, -32768);
        send_load(1023, 32767, -32768, 0);
        send_load(5, -32768, 32767, 32767);
        send_load(6, 0, 0, 0);
        send_load(7, 100, 200, 300);
        send_load(8, 200, 400, 600);
        send_tri(0, 1023, 5);
        send_tri(6, 7, 8);
        send_tri(7, 7, 7);
        send_tri(6, 1023, 5);
        send_tri(6, 5, 1023);
        send_read(0);
        send_read(1023);
        send_read(5);
        send_read(6);
        send_read(7);
        send_read(512);
        send_tri(0, 0, 5);
        send_read(0);
        send_clear();
        send_read(0);
        send_read(1023);
        send_tri(1023, 0, 5);
        send_read(1023);
    endtask

    // Mostly well-formed mesh traffic over a random pool of vertices
    task automatic test_random_mesh(input int beats);
        int roll;
        int coord_lim;
        for (int n = 0; n < beats; n++)
        begin
            calm = (n >= beats / 3) && (n < beats / 3 + 80);
            roll = $urandom_range(99);
            coord_lim = ($urandom_range(3) == 0) ? 32767 : 2000;
            if (roll < 20 || loaded_list.size() < 3)
                send_load($urandom_range(1023),
                          int'($urandom_range(2 * coord_lim)) - coord_lim,
                          int'($urandom_range(2 * coord_lim)) - coord_lim,
                          int'($urandom_range(2 * coord_lim)) - coord_lim);
            else if (roll < 65)
                send_tri(pick_loaded(), pick_loaded(), pick_loaded());
            else if (roll < 90)
                send_read(pick_loaded());
            else if (roll < 98)
                send_read($urandom_range(1023));
            else
                send_clear();
        end
        calm = 1'b0;
    endtask

    // Hold off the receiver so the block fills and stalls its input
    task automatic test_backpressure();
        hold_go = 1'b1;
        for (int n = 0; n < 8; n++)
            send_read(pick_loaded());
    endtask

    // Count the long receiver hold-off once it is requested
    initial
    begin
        hold_on = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Check one accepted result beat against the oldest expectation
    always @(posedge clk)
    begin
        normal_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (normal_q.size() == 0)
            begin
                $display("%0t: unexpected result beat index %0d", $time, out_index);
                errors++;
            end
            else
            begin
                want = normal_q.pop_front();
                reads_checked++;
                if (out_index !== want.idx)
                begin
                    $display("%0t: out_index exp %0d act %0d", $time, want.idx, out_index);
                    errors++;
                end
                if (normal_x !== want.nx)
                begin
                    $display("%0t: normal_x exp %h act %h", $time, want.nx, normal_x);
                    errors++;
                end
                if (normal_y !== want.ny)
                begin
                    $display("%0t: normal_y exp %h act %h", $time, want.ny, normal_y);
                    errors++;
                end
                if (normal_z !== want.nz)
                begin
                    $display("%0t: normal_z exp %h act %h", $time, want.nz, normal_z);
                    errors++;
                end
                if (face_count !== want.cnt)
                begin
                    $display("%0t: face_count exp %0d act %0d", $time, want.cnt, face_count);
                    errors++;
                end
                if (no_normal !== want.none)
                begin
                    $display("%0t: no_normal exp %b act %b", $time, want.none, no_normal);
                    errors++;
                end
            end
        end
        // Drive the receiver stall for the next edge
        out_stall <= hold_on || (!calm && $urandom_range(99) < 18);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        beats_sent = 0;
        reads_checked = 0;
        tris_sent = 0;
        cycle_cnt = 0;
        calm = 1'b0;
        hold_go = 1'b0;
        for (int i = 0; i < VertexSlots; i++)
        begin
            vert_loaded[i] = 1'b0;
            touch_cnt[i] = 0;
            for (int j = 0; j < 3; j++)
            begin
                vert_pos[i][j] = 0;
                acc_sum[i][j] = 0;
            end
        end
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        operation = OP_LOAD;
        vertex_index = '0;
        vertex_x = '0;
        vertex_y = '0;
        vertex_z = '0;
        corner_a = '0;
        corner_b = '0;
        corner_c = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mesh(200);
        test_backpressure();
        test_random_mesh(200);
        in_valid <= 1'b0;

        // Drain outstanding results, then let trailing work settle
        while (normal_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Sent %0d beats (%0d triangles), checked %0d normal reads,",
                 beats_sent, tris_sent, reads_checked);
        $display("with random idling, a long output hold-off and clears; %0d errors.",
                 errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
rtl/mvn_pkg.sv
rtl/mvn_normalize.sv
rtl/mesh_vertex_normal_engine.sv
tb/sv/mesh_vertex_normal_engine_tb.sv
